// ----- rtl/vtesc_pkg.sv -----
// shared constants, byte codes and controller/datapath interface types
// for the vt escape sequence parser; no dependencies
package vtesc_pkg;

  // default number of stored csi parameters
  localparam int unsigned MAX_PARAMS_DEF = 16;

  // control and class boundary bytes
  localparam logic [7:0] CH_ESC      = 8'h1B;
  localparam logic [7:0] CH_BEL      = 8'h07;
  localparam logic [7:0] CH_CR       = 8'h0D;
  localparam logic [7:0] CH_LF       = 8'h0A;
  localparam logic [7:0] CH_BS       = 8'h08;
  localparam logic [7:0] CH_TAB      = 8'h09;
  localparam logic [7:0] CH_SP       = 8'h20;
  localparam logic [7:0] CH_INTER_HI = 8'h2F;
  localparam logic [7:0] CH_FINAL_LO = 8'h40;
  localparam logic [7:0] CH_FINAL_HI = 8'h7E;
  localparam logic [7:0] CH_ZERO     = 8'h30;
  localparam logic [7:0] CH_NINE     = 8'h39;
  localparam logic [7:0] CH_COLON    = 8'h3A;
  localparam logic [7:0] CH_SEMI     = 8'h3B;
  localparam logic [7:0] CH_QUEST    = 8'h3F;
  localparam logic [7:0] CH_LBRK     = 8'h5B;
  localparam logic [7:0] CH_RBRK     = 8'h5D;

  // escape and csi final bytes
  localparam logic [7:0] CH_A    = 8'h41;
  localparam logic [7:0] CH_B    = 8'h42;
  localparam logic [7:0] CH_C    = 8'h43;
  localparam logic [7:0] CH_D    = 8'h44;
  localparam logic [7:0] CH_E    = 8'h45;
  localparam logic [7:0] CH_F    = 8'h46;
  localparam logic [7:0] CH_H    = 8'h48;
  localparam logic [7:0] CH_J    = 8'h4A;
  localparam logic [7:0] CH_K    = 8'h4B;
  localparam logic [7:0] CH_M    = 8'h4D;
  localparam logic [7:0] CH_S    = 8'h53;
  localparam logic [7:0] CH_T    = 8'h54;
  localparam logic [7:0] CH_LC_F = 8'h66;
  localparam logic [7:0] CH_LC_M = 8'h6D;
  localparam logic [7:0] CH_LC_R = 8'h72;

  // event kinds
  localparam logic [3:0] EV_TEXT   = 4'd0;
  localparam logic [3:0] EV_BELL   = 4'd1;
  localparam logic [3:0] EV_SUP    = 4'd2;
  localparam logic [3:0] EV_SDN    = 4'd3;
  localparam logic [3:0] EV_POS    = 4'd4;
  localparam logic [3:0] EV_UP     = 4'd5;
  localparam logic [3:0] EV_DOWN   = 4'd6;
  localparam logic [3:0] EV_FWD    = 4'd7;
  localparam logic [3:0] EV_BACK   = 4'd8;
  localparam logic [3:0] EV_ED     = 4'd9;
  localparam logic [3:0] EV_EL     = 4'd10;
  localparam logic [3:0] EV_REGION = 4'd11;
  localparam logic [3:0] EV_SGR    = 4'd12;

  // source of a result loaded into the output register
  typedef enum logic [2:0] {
    SRC_TEXT,
    SRC_BELL,
    SRC_SUP1,
    SRC_SDN1,
    SRC_FINAL,
    SRC_POS01,
    SRC_SGR
  } src_e;

  // what a csi final byte produces
  typedef enum logic [1:0] {
    FIN_NONE,
    FIN_ONE,
    FIN_TWO,
    FIN_RUN
  } fin_e;

  // controller to datapath commands
  typedef struct packed {
    logic csi_start;
    logic par_entry;
    logic par_byte;
    logic fin_commit;
    logic sgr_rd;
    logic out_load;
    src_e out_src;
    logic out_last;
  } cmd_t;

  // datapath to controller status
  typedef struct packed {
    fin_e fin_class;
    logic sgr_last;
  } sts_t;

endpackage

// ----- rtl/vtesc_ctrl.sv -----
// parse state machine and result sequencing for the vt escape sequence parser
// depends on vtesc_pkg; drives vtesc_dp through cmd_t and reads sts_t
module vtesc_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic [7:0]         in_byte_i,
  output logic               in_ready_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  input  vtesc_pkg::sts_t    sts_i,
  output vtesc_pkg::cmd_t    cmd_o
);

  localparam logic [3:0] ST_GROUND  = 4'd0;
  localparam logic [3:0] ST_ESC     = 4'd1;
  localparam logic [3:0] ST_ENTRY   = 4'd2;
  localparam logic [3:0] ST_PARAM   = 4'd3;
  localparam logic [3:0] ST_INTER   = 4'd4;
  localparam logic [3:0] ST_OSC     = 4'd5;
  localparam logic [3:0] ST_EPOS    = 4'd6;
  localparam logic [3:0] ST_SGR_RD  = 4'd7;
  localparam logic [3:0] ST_SGR_OUT = 4'd8;

  logic [3:0]      state_q, state_d;
  logic            out_valid_q, out_valid_d;
  logic            out_free;
  logic            parse_st;
  logic            take;
  logic            is_digit, is_inter, is_final, is_text;
  logic            is_entry_byte, is_param_byte;
  logic            fin_take;
  vtesc_pkg::cmd_t cmd;

  // byte classes
  assign is_digit = (in_byte_i >= vtesc_pkg::CH_ZERO) && (in_byte_i <= vtesc_pkg::CH_NINE);
  assign is_inter = (in_byte_i >= vtesc_pkg::CH_SP) && (in_byte_i <= vtesc_pkg::CH_INTER_HI);
  assign is_final = (in_byte_i >= vtesc_pkg::CH_FINAL_LO)
                 && (in_byte_i <= vtesc_pkg::CH_FINAL_HI);
  assign is_text  = (in_byte_i >= vtesc_pkg::CH_SP) || (in_byte_i == vtesc_pkg::CH_CR)
                 || (in_byte_i == vtesc_pkg::CH_LF) || (in_byte_i == vtesc_pkg::CH_BS)
                 || (in_byte_i == vtesc_pkg::CH_TAB);
  assign is_entry_byte = is_digit || (in_byte_i == vtesc_pkg::CH_SEMI)
                      || (in_byte_i == vtesc_pkg::CH_QUEST);
  assign is_param_byte = is_entry_byte || (in_byte_i == vtesc_pkg::CH_COLON);

  // handshake: bytes are taken in parse states while the output register can move
  assign out_free = !out_valid_q || out_ready_i;
  assign parse_st = (state_q == ST_GROUND) || (state_q == ST_ESC) || (state_q == ST_ENTRY)
                 || (state_q == ST_PARAM) || (state_q == ST_INTER) || (state_q == ST_OSC);
  assign in_ready_o = parse_st && out_free;
  assign take       = in_valid_i && in_ready_o;
  assign fin_take   = take && is_final
                   && ((state_q == ST_ENTRY) || (state_q == ST_PARAM) || (state_q == ST_INTER));

  // next state and commands
  always_comb begin
    state_d = state_q;
    cmd     = '0;
    unique case (state_q)
      ST_GROUND: begin
        if (take) begin
          if (in_byte_i == vtesc_pkg::CH_ESC) begin
            state_d = ST_ESC;
          end else if (in_byte_i == vtesc_pkg::CH_BEL) begin
            cmd.out_load = 1'b1;
            cmd.out_src  = vtesc_pkg::SRC_BELL;
            cmd.out_last = 1'b1;
          end else if (is_text) begin
            cmd.out_load = 1'b1;
            cmd.out_src  = vtesc_pkg::SRC_TEXT;
            cmd.out_last = 1'b1;
          end
        end
      end
      ST_ESC: begin
        if (take) begin
          state_d = ST_GROUND;
          if (in_byte_i == vtesc_pkg::CH_LBRK) begin
            cmd.csi_start = 1'b1;
            state_d       = ST_ENTRY;
          end else if (in_byte_i == vtesc_pkg::CH_RBRK) begin
            state_d = ST_OSC;
          end else if (in_byte_i == vtesc_pkg::CH_D) begin
            cmd.out_load = 1'b1;
            cmd.out_src  = vtesc_pkg::SRC_SUP1;
            cmd.out_last = 1'b1;
          end else if (in_byte_i == vtesc_pkg::CH_M) begin
            cmd.out_load = 1'b1;
            cmd.out_src  = vtesc_pkg::SRC_SDN1;
            cmd.out_last = 1'b1;
          end
        end
      end
      ST_ENTRY: begin
        if (take) begin
          if (is_entry_byte) begin
            cmd.par_entry = 1'b1;
            state_d       = ST_PARAM;
          end else if (is_inter) begin
            state_d = ST_INTER;
          end
        end
      end
      ST_PARAM: begin
        if (take) begin
          if (is_param_byte) begin
            cmd.par_byte = 1'b1;
          end else if (is_inter) begin
            state_d = ST_INTER;
          end
        end
      end
      ST_INTER: begin
      end
      ST_OSC: begin
        if (take) begin
          if (in_byte_i == vtesc_pkg::CH_BEL) begin
            state_d = ST_GROUND;
          end else if (in_byte_i == vtesc_pkg::CH_ESC) begin
            state_d = ST_ESC;
          end
        end
      end
      ST_EPOS: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_src  = vtesc_pkg::SRC_POS01;
          cmd.out_last = 1'b1;
          state_d      = ST_GROUND;
        end
      end
      ST_SGR_RD: begin
        cmd.sgr_rd = 1'b1;
        state_d    = ST_SGR_OUT;
      end
      ST_SGR_OUT: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_src  = vtesc_pkg::SRC_SGR;
          cmd.out_last = sts_i.sgr_last;
          state_d      = sts_i.sgr_last ? ST_GROUND : ST_SGR_RD;
        end
      end
      default: begin
        state_d = ST_GROUND;
      end
    endcase

    // csi final byte, common to entry, parameter and intermediate states
    if (fin_take) begin
      cmd.fin_commit = 1'b1;
      unique case (sts_i.fin_class)
        vtesc_pkg::FIN_ONE: begin
          cmd.out_load = 1'b1;
          cmd.out_src  = vtesc_pkg::SRC_FINAL;
          cmd.out_last = 1'b1;
          state_d      = ST_GROUND;
        end
        vtesc_pkg::FIN_TWO: begin
          cmd.out_load = 1'b1;
          cmd.out_src  = vtesc_pkg::SRC_FINAL;
          cmd.out_last = 1'b0;
          state_d      = ST_EPOS;
        end
        vtesc_pkg::FIN_RUN: begin
          state_d = ST_SGR_RD;
        end
        default: begin
          state_d = ST_GROUND;
        end
      endcase
    end
  end

  // output valid flag
  always_comb begin
    if (cmd.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_GROUND;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign cmd_o       = cmd;

`ifndef SYNTH
  // a result never overwrites one still waiting downstream
  a_load_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.out_load |-> (!out_valid_q || out_ready_i))
    else $error("output register loaded while occupied");

  // a result that is not last of its byte is always followed by more
  a_more_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.out_load && !cmd.out_last) |=> (state_q == ST_EPOS || state_q == ST_SGR_RD))
    else $error("run ended without a last result");
`endif

endmodule

// ----- rtl/vtesc_dp.sv -----
// csi parameter storage, final byte decode and output register
// for the vt escape sequence parser; depends on vtesc_pkg
module vtesc_dp #(
  parameter int unsigned MAX_PARAMS = vtesc_pkg::MAX_PARAMS_DEF
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic [7:0]      in_byte_i,
  input  vtesc_pkg::cmd_t cmd_i,
  output vtesc_pkg::sts_t sts_o,
  output logic [3:0]      event_kind_o,
  output logic [15:0]     arg_one_o,
  output logic [15:0]     arg_two_o,
  output logic            last_of_run_o
);

  localparam int unsigned IW = $clog2(MAX_PARAMS);
  localparam int unsigned CW = $clog2(MAX_PARAMS + 2);

  // parameter state
  logic [CW-1:0]  count_q, count_d;
  logic           inval_q, inval_d;
  logic           priv_q, priv_d;
  logic [IW-1:0]  idx_q, idx_d;
  logic [15:0]    acc_q, acc_d;
  logic [15:0]    p0_q, p1_q;
  logic [15:0]    rdata_q;
  logic [15:0]    store_mem [MAX_PARAMS];

  // write port
  logic           wr_en;
  logic [IW-1:0]  wr_addr;
  logic [15:0]    wr_data;

  // output register
  logic [3:0]     kind_q;
  logic [15:0]    a_q, b_q;
  logic           last_q;

  logic           live;
  logic [CW-1:0]  cur;
  logic [CW-1:0]  n_cnt;
  logic           is_digit, is_semi, is_sep_bad;
  logic [19:0]    acc_ext;
  logic [15:0]    acc_sat;
  logic [15:0]    part0, part1;
  logic [15:0]    arg0_d1, arg0_d0, arg1_d1;
  vtesc_pkg::fin_e fin_class;
  logic [3:0]     fin_kind;
  logic [15:0]    fin_a, fin_b;

  assign is_digit   = (in_byte_i >= vtesc_pkg::CH_ZERO) && (in_byte_i <= vtesc_pkg::CH_NINE);
  assign is_semi    = (in_byte_i == vtesc_pkg::CH_SEMI);
  assign is_sep_bad = (in_byte_i == vtesc_pkg::CH_COLON) || (in_byte_i == vtesc_pkg::CH_QUEST);

  // current part index and part count in use
  assign live  = (count_q != '0) && (count_q <= CW'(MAX_PARAMS));
  assign cur   = count_q - 1'b1;
  assign n_cnt = (count_q > CW'(MAX_PARAMS)) ? CW'(MAX_PARAMS) : count_q;

  // decimal accumulate with saturation
  assign acc_ext = {1'b0, acc_q, 3'b000} + {3'b000, acc_q, 1'b0} + {16'd0, in_byte_i[3:0]};
  assign acc_sat = (acc_ext > 20'd65535) ? 16'hFFFF : acc_ext[15:0];

  // parameter bookkeeping
  always_comb begin
    count_d = count_q;
    inval_d = inval_q;
    priv_d  = priv_q;
    acc_d   = acc_q;
    idx_d   = idx_q;
    wr_en   = 1'b0;
    wr_addr = cur[IW-1:0];
    wr_data = acc_q;
    if (cmd_i.csi_start) begin
      count_d = '0;
      inval_d = 1'b0;
      priv_d  = 1'b0;
    end
    if (cmd_i.par_entry) begin
      if (is_semi) begin
        // empty first part closes at once
        wr_en   = 1'b1;
        wr_addr = '0;
        wr_data = '0;
        count_d = CW'(2);
        acc_d   = '0;
        inval_d = 1'b0;
      end else if (is_digit) begin
        count_d = CW'(1);
        acc_d   = {12'd0, in_byte_i[3:0]};
        inval_d = 1'b0;
      end else begin
        count_d = CW'(1);
        acc_d   = '0;
        inval_d = 1'b1;
        priv_d  = 1'b1;
      end
    end
    if (cmd_i.par_byte) begin
      if (is_semi) begin
        wr_en   = live;
        if (count_q <= CW'(MAX_PARAMS)) begin
          count_d = count_q + 1'b1;
        end
        acc_d   = '0;
        inval_d = 1'b0;
      end else if (is_sep_bad) begin
        inval_d = 1'b1;
        acc_d   = '0;
      end else if (!inval_q) begin
        acc_d = acc_sat;
      end
    end
    if (cmd_i.fin_commit) begin
      wr_en = live;
      idx_d = '0;
    end
    if (cmd_i.out_load && (cmd_i.out_src == vtesc_pkg::SRC_SGR)) begin
      idx_d = idx_q + 1'b1;
    end
  end

  // part values and defaults seen by a final byte
  assign part0   = (count_q == CW'(1)) ? acc_q : p0_q;
  assign part1   = (count_q == CW'(2)) ? acc_q : p1_q;
  assign arg0_d1 = ((count_q != '0) && (part0 != '0)) ? part0 : 16'd1;
  assign arg0_d0 = (count_q != '0) ? part0 : 16'd0;
  assign arg1_d1 = ((count_q >= CW'(2)) && (part1 != '0)) ? part1 : 16'd1;

  // final byte decode
  always_comb begin
    fin_class = vtesc_pkg::FIN_NONE;
    fin_kind  = vtesc_pkg::EV_TEXT;
    fin_a     = '0;
    fin_b     = '0;
    if (!priv_q) begin
      unique case (in_byte_i) inside
        vtesc_pkg::CH_LC_M: begin
          fin_kind  = vtesc_pkg::EV_SGR;
          fin_class = (count_q == '0) ? vtesc_pkg::FIN_ONE : vtesc_pkg::FIN_RUN;
        end
        vtesc_pkg::CH_H, vtesc_pkg::CH_LC_F: begin
          fin_class = vtesc_pkg::FIN_ONE;
          fin_kind  = vtesc_pkg::EV_POS;
          fin_a     = arg0_d1;
          fin_b     = arg1_d1;
        end
        vtesc_pkg::CH_A, vtesc_pkg::CH_F: begin
          fin_class = vtesc_pkg::FIN_ONE;
          fin_kind  = vtesc_pkg::EV_UP;
          fin_a     = arg0_d1;
        end
        vtesc_pkg::CH_B: begin
          fin_class = vtesc_pkg::FIN_ONE;
          fin_kind  = vtesc_pkg::EV_DOWN;
          fin_a     = arg0_d1;
        end
        vtesc_pkg::CH_C: begin
          fin_class = vtesc_pkg::FIN_ONE;
          fin_kind  = vtesc_pkg::EV_FWD;
          fin_a     = arg0_d1;
        end
        vtesc_pkg::CH_D: begin
          fin_class = vtesc_pkg::FIN_ONE;
          fin_kind  = vtesc_pkg::EV_BACK;
          fin_a     = arg0_d1;
        end
        vtesc_pkg::CH_J: begin
          fin_class = vtesc_pkg::FIN_ONE;
          fin_kind  = vtesc_pkg::EV_ED;
          fin_a     = arg0_d0;
        end
        vtesc_pkg::CH_K: begin
          fin_class = vtesc_pkg::FIN_ONE;
          fin_kind  = vtesc_pkg::EV_EL;
          fin_a     = arg0_d0;
        end
        vtesc_pkg::CH_S: begin
          fin_class = vtesc_pkg::FIN_ONE;
          fin_kind  = vtesc_pkg::EV_SUP;
          fin_a     = arg0_d1;
        end
        vtesc_pkg::CH_T: begin
          fin_class = vtesc_pkg::FIN_ONE;
          fin_kind  = vtesc_pkg::EV_SDN;
          fin_a     = arg0_d1;
        end
        vtesc_pkg::CH_LC_R: begin
          fin_class = vtesc_pkg::FIN_ONE;
          fin_kind  = vtesc_pkg::EV_REGION;
          if (count_q >= CW'(2)) begin
            fin_a = part0;
            fin_b = part1;
          end else begin
            fin_a = 16'd1;
          end
        end
        vtesc_pkg::CH_E: begin
          fin_class = vtesc_pkg::FIN_TWO;
          fin_kind  = vtesc_pkg::EV_DOWN;
          fin_a     = arg0_d1;
        end
        default: begin
        end
      endcase
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      inval_q <= 1'b0;
      priv_q  <= 1'b0;
      idx_q   <= '0;
    end else begin
      count_q <= count_d;
      inval_q <= inval_d;
      priv_q  <= priv_d;
      idx_q   <= idx_d;
    end
  end

  // accumulator and shadows of the first two parts
  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    if (wr_en && (wr_addr == IW'(0))) begin
      p0_q <= wr_data;
    end
    if (wr_en && (wr_addr == IW'(1))) begin
      p1_q <= wr_data;
    end
  end

  // parameter memory, one write and one registered read
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      store_mem[wr_addr] <= wr_data;
    end
    if (cmd_i.sgr_rd) begin
      rdata_q <= store_mem[idx_q];
    end
  end

  // output register
  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      last_q <= cmd_i.out_last;
      case (cmd_i.out_src)
        vtesc_pkg::SRC_TEXT: begin
          kind_q <= vtesc_pkg::EV_TEXT;
          a_q    <= {8'd0, in_byte_i};
          b_q    <= '0;
        end
        vtesc_pkg::SRC_BELL: begin
          kind_q <= vtesc_pkg::EV_BELL;
          a_q    <= '0;
          b_q    <= '0;
        end
        vtesc_pkg::SRC_SUP1: begin
          kind_q <= vtesc_pkg::EV_SUP;
          a_q    <= 16'd1;
          b_q    <= '0;
        end
        vtesc_pkg::SRC_SDN1: begin
          kind_q <= vtesc_pkg::EV_SDN;
          a_q    <= 16'd1;
          b_q    <= '0;
        end
        vtesc_pkg::SRC_FINAL: begin
          kind_q <= fin_kind;
          a_q    <= fin_a;
          b_q    <= fin_b;
        end
        vtesc_pkg::SRC_POS01: begin
          kind_q <= vtesc_pkg::EV_POS;
          a_q    <= '0;
          b_q    <= 16'd1;
        end
        vtesc_pkg::SRC_SGR: begin
          kind_q <= vtesc_pkg::EV_SGR;
          a_q    <= rdata_q;
          b_q    <= '0;
        end
        default: begin
          kind_q <= vtesc_pkg::EV_TEXT;
          a_q    <= '0;
          b_q    <= '0;
        end
      endcase
    end
  end

  assign sts_o.fin_class = fin_class;
  assign sts_o.sgr_last  = (CW'(idx_q) == (n_cnt - 1'b1));
  assign event_kind_o    = kind_q;
  assign arg_one_o       = a_q;
  assign arg_two_o       = b_q;
  assign last_of_run_o   = last_q;

`ifndef SYNTH
  // the part count saturates one past the stored parts
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(MAX_PARAMS + 1))
    else $error("parameter count out of range");

  // an sgr run only reads stored parts
  a_sgr_has_parts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.sgr_rd |-> (count_q != '0 && CW'(idx_q) < n_cnt))
    else $error("sgr read past the stored parts");
`endif

endmodule

// ----- rtl/vt_escape_sequence_parser.sv -----
// top level of the vt escape sequence parser: stream ports, controller and datapath
// depends on vtesc_pkg, vtesc_ctrl and vtesc_dp
//
// Takes one terminal byte per transaction and returns text, bell, scroll, cursor,
// erase, scroll-region and sgr events. A byte is taken in a parse state whenever the
// output register is empty or being drained, so plain text and escape or parameter
// bytes flow at one byte per cycle. A csi 'E' holds the input for its second result.
// An sgr final byte with n stored parameters holds the input for one parameter
// memory read and one output load per parameter, in turn, since the parameter memory
// has a single read port. Every result of a byte carries tlast on its final one.
module vt_escape_sequence_parser #(
  parameter int unsigned MAX_PARAMS = vtesc_pkg::MAX_PARAMS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] in_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [15:0] arg_one, [31:16] arg_two
  output logic [3:0]  m_axis_tuser,   // [3:0] event_kind
  output logic        m_axis_tlast
);

  vtesc_pkg::cmd_t cmd;
  vtesc_pkg::sts_t sts;
  logic [15:0]     arg_one;
  logic [15:0]     arg_two;

  // parse and sequencing control
  vtesc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_byte_i   (s_axis_tdata),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // parameters, decode and output register
  vtesc_dp #(
    .MAX_PARAMS (MAX_PARAMS)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_byte_i     (s_axis_tdata),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .event_kind_o  (m_axis_tuser),
    .arg_one_o     (arg_one),
    .arg_two_o     (arg_two),
    .last_of_run_o (m_axis_tlast)
  );

  assign m_axis_tdata = {arg_two, arg_one};

endmodule

// ----- test/vt_escape_sequence_parser_tb.sv -----
`timescale 1ns / 1ps
// self-checking testbench for vt_escape_sequence_parser: byte driver, event monitor
// and an in-bench parser that predicts every event; depends on vtesc_pkg and the rtl
module vt_escape_sequence_parser_tb;
  import vtesc_pkg::*;

  localparam int unsigned NPARAM = MAX_PARAMS_DEF;
  localparam int unsigned HOLD_CYCLES = 300;

  typedef enum logic [2:0] {
    PM_GROUND,
    PM_ESC,
    PM_ENTRY,
    PM_PARAM,
    PM_INTER,
    PM_OSC
  } parse_mode_e;

  typedef struct packed {
    logic [3:0]  kind;
    logic [15:0] arg_one;
    logic [15:0] arg_two;
    logic        last_of_run;
  } vt_event_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = 8'h00;   // [7:0] in_byte
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;           // [15:0] arg_one, [31:16] arg_two
  logic [3:0]  m_axis_tuser;           // [3:0] event_kind
  logic        m_axis_tlast;

  // stimulus and expectation stores
  logic [7:0]  byte_q[$];
  vt_event_t   event_q[$];
  int unsigned idle_pct = 0;
  int unsigned stall_pct = 0;
  logic        hold_go = 1'b0;
  logic        hold_on = 1'b0;
  int          err_cnt = 0;

  // parser state mirrored by the predictor
  parse_mode_e pmode = PM_GROUND;
  logic [15:0] part_val[NPARAM];
  int unsigned part_cnt = 0;
  logic        part_bad = 1'b0;
  logic        priv_seq = 1'b0;

  vt_escape_sequence_parser #(
    .MAX_PARAMS(NPARAM)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast)
  );

  always #1 clk_i = ~clk_i;

  // ---------------------------------------------------------------- predictor

  task automatic queue_event(input logic [3:0] kind, input logic [15:0] a1,
                             input logic [15:0] a2);
    vt_event_t ev;
    ev.kind = kind;
    ev.arg_one = a1;
    ev.arg_two = a2;
    ev.last_of_run = 1'b0;
    event_q.push_back(ev);
  endtask

  function automatic int unsigned used_parts();
    return (part_cnt > NPARAM) ? NPARAM : part_cnt;
  endfunction

  // stored part if present and nonzero, else the command default
  function automatic logic [15:0] part_or(input int unsigned i, input logic [15:0] dflt);
    if (i < used_parts() && part_val[i] != 16'd0) return part_val[i];
    return dflt;
  endfunction

  // new part; parts past the store are only counted
  task automatic open_part();
    if (part_cnt <= NPARAM) part_cnt++;
    if (part_cnt <= NPARAM) part_val[part_cnt-1] = 16'd0;
    part_bad = 1'b0;
  endtask

  task automatic take_part_byte(input logic [7:0] b);
    int unsigned cur;
    int unsigned v;
    logic        live;
    cur = part_cnt - 1;
    live = (part_cnt >= 1) && (part_cnt <= NPARAM);
    if (b == CH_SEMI) begin
      open_part();
    end else if (b == CH_COLON || b == CH_QUEST) begin
      // colon or question mark spoils the part to zero
      part_bad = 1'b1;
      if (live) part_val[cur] = 16'd0;
    end else if (live && !part_bad) begin
      v = int'(part_val[cur]) * 10 + int'(b - CH_ZERO);
      part_val[cur] = (v > 65535) ? 16'hFFFF : v[15:0];
    end
  endtask

  task automatic decode_final(input logic [7:0] f);
    int unsigned n;
    n = used_parts();
    if (!priv_seq) begin
      case (f)
        CH_LC_M: begin
          if (n == 0) queue_event(EV_SGR, 16'd0, 16'd0);
          for (int unsigned i = 0; i < n; i++) queue_event(EV_SGR, part_val[i], 16'd0);
        end
        CH_H, CH_LC_F: queue_event(EV_POS, part_or(0, 16'd1), part_or(1, 16'd1));
        CH_A, CH_F:    queue_event(EV_UP, part_or(0, 16'd1), 16'd0);
        CH_B:          queue_event(EV_DOWN, part_or(0, 16'd1), 16'd0);
        CH_C:          queue_event(EV_FWD, part_or(0, 16'd1), 16'd0);
        CH_D:          queue_event(EV_BACK, part_or(0, 16'd1), 16'd0);
        CH_J:          queue_event(EV_ED, part_or(0, 16'd0), 16'd0);
        CH_K:          queue_event(EV_EL, part_or(0, 16'd0), 16'd0);
        CH_S:          queue_event(EV_SUP, part_or(0, 16'd1), 16'd0);
        CH_T:          queue_event(EV_SDN, part_or(0, 16'd1), 16'd0);
        CH_LC_R: begin
          if (n >= 2) queue_event(EV_REGION, part_val[0], part_val[1]);
          else queue_event(EV_REGION, 16'd1, 16'd0);
        end
        CH_E: begin
          queue_event(EV_DOWN, part_or(0, 16'd1), 16'd0);
          queue_event(EV_POS, 16'd0, 16'd1);
        end
        default: ;
      endcase
    end
  endtask

  // one accepted byte: advance the parser and queue its events
  task automatic decode_byte(input logic [7:0] b);
    int unsigned first;
    logic        is_digit;
    logic        is_inter;
    logic        is_final;
    vt_event_t   ev;
    first = event_q.size();
    is_digit = (b >= CH_ZERO) && (b <= CH_NINE);
    is_inter = (b >= CH_SP) && (b <= CH_INTER_HI);
    is_final = (b >= CH_FINAL_LO) && (b <= CH_FINAL_HI);
    case (pmode)
      PM_ESC: begin
        pmode = PM_GROUND;
        if (b == CH_LBRK) begin
          part_cnt = 0;
          part_bad = 1'b0;
          priv_seq = 1'b0;
          pmode = PM_ENTRY;
        end else if (b == CH_RBRK) begin
          pmode = PM_OSC;
        end else if (b == CH_D) begin
          queue_event(EV_SUP, 16'd1, 16'd0);
        end else if (b == CH_M) begin
          queue_event(EV_SDN, 16'd1, 16'd0);
        end
      end
      PM_ENTRY: begin
        if (is_digit || b == CH_SEMI || b == CH_QUEST) begin
          if (b == CH_QUEST) priv_seq = 1'b1;
          open_part();
          take_part_byte(b);
          pmode = PM_PARAM;
        end else if (is_inter) begin
          pmode = PM_INTER;
        end else if (is_final) begin
          decode_final(b);
          pmode = PM_GROUND;
        end
      end
      PM_PARAM: begin
        if (is_digit || b == CH_SEMI || b == CH_QUEST || b == CH_COLON) begin
          take_part_byte(b);
        end else if (is_inter) begin
          pmode = PM_INTER;
        end else if (is_final) begin
          decode_final(b);
          pmode = PM_GROUND;
        end
      end
      PM_INTER: begin
        if (is_final) begin
          decode_final(b);
          pmode = PM_GROUND;
        end
      end
      PM_OSC: begin
        if (b == CH_BEL) pmode = PM_GROUND;
        else if (b == CH_ESC) pmode = PM_ESC;
      end
      default: begin
        pmode = PM_GROUND;
        if (b == CH_ESC) pmode = PM_ESC;
        else if (b == CH_BEL) queue_event(EV_BELL, 16'd0, 16'd0);
        else if (b >= CH_SP || b == CH_CR || b == CH_LF || b == CH_BS || b == CH_TAB)
          queue_event(EV_TEXT, {8'h00, b}, 16'd0);
      end
    endcase
    // tag the final event of this byte
    if (event_q.size() > first) begin
      ev = event_q.pop_back();
      ev.last_of_run = 1'b1;
      event_q.push_back(ev);
    end
  endtask

  // ---------------------------------------------------------------- driver

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata <= 8'h00;
    end else begin
      if (s_axis_tvalid && s_axis_tready) decode_byte(s_axis_tdata);
      // offer the next byte once the current transaction is gone
      if (!s_axis_tvalid || s_axis_tready) begin
        if (byte_q.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
          s_axis_tvalid <= 1'b1;
          s_axis_tdata <= byte_q.pop_front();
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------- monitor

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (event_q.size() == 0) begin
          $error("unexpected event: kind %0d arg_one %0d arg_two %0d last %0b",
                 m_axis_tuser, m_axis_tdata[15:0], m_axis_tdata[31:16], m_axis_tlast);
          err_cnt++;
        end else begin
          vt_event_t ev;
          ev = event_q.pop_front();
          if (m_axis_tuser !== ev.kind) begin
            $error("event_kind: expected %0d, got %0d", ev.kind, m_axis_tuser);
            err_cnt++;
          end
          if (m_axis_tdata[15:0] !== ev.arg_one) begin
            $error("arg_one: expected %0d, got %0d", ev.arg_one, m_axis_tdata[15:0]);
            err_cnt++;
          end
          if (m_axis_tdata[31:16] !== ev.arg_two) begin
            $error("arg_two: expected %0d, got %0d", ev.arg_two, m_axis_tdata[31:16]);
            err_cnt++;
          end
          if (m_axis_tlast !== ev.last_of_run) begin
            $error("last_of_run: expected %0b, got %0b", ev.last_of_run, m_axis_tlast);
            err_cnt++;
          end
        end
      end
      m_axis_tready <= !hold_on && ($urandom_range(0, 99) >= stall_pct);
    end
  end

  // long receiver hold-off so the output backs up into the input
  initial begin
    wait (hold_go);
    @(posedge clk_i);
    hold_on <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk_i);
    hold_on <= 1'b0;
  end

  // ---------------------------------------------------------------- stimulus

  task automatic push_digits(input int unsigned ndig);
    logic all_nines;
    all_nines = ($urandom_range(0, 1) == 0);
    for (int unsigned d = 0; d < ndig; d++)
      byte_q.push_back(all_nines ? CH_NINE : CH_ZERO + 8'($urandom_range(0, 9)));
  endtask

  // mostly well-formed sequences with random content, plus text and noise
  task automatic gen_stream(input int unsigned n_bytes);
    int unsigned start;
    int unsigned r;
    int unsigned nparts;
    logic [7:0]  finals[16];
    finals = '{CH_LC_M, CH_LC_M, CH_LC_M, CH_H, CH_LC_F, CH_A, CH_F, CH_B,
               CH_C, CH_D, CH_J, CH_K, CH_S, CH_T, CH_LC_R, CH_E};
    start = byte_q.size();
    while (byte_q.size() - start < n_bytes) begin
      r = $urandom_range(0, 99);
      if (r < 45) begin
        // csi sequence
        byte_q.push_back(CH_ESC);
        byte_q.push_back(CH_LBRK);
        if ($urandom_range(0, 9) == 0) byte_q.push_back(CH_QUEST);
        r = $urandom_range(0, 99);
        if (r < 5) nparts = $urandom_range(NPARAM + 1, NPARAM + 3);
        else if (r < 15) nparts = 0;
        else nparts = $urandom_range(1, 4);
        for (int unsigned p = 0; p < nparts; p++) begin
          if (p != 0) byte_q.push_back(CH_SEMI);
          if ($urandom_range(0, 14) == 0) push_digits(5);
          else push_digits($urandom_range(0, 3));
          if ($urandom_range(0, 29) == 0) byte_q.push_back(CH_COLON);
          // stray bytes that the csi states ignore
          if ($urandom_range(0, 29) == 0) begin
            case ($urandom_range(0, 3))
              0: byte_q.push_back(CH_ESC);
              1: byte_q.push_back(8'($urandom_range(0, 31)));
              2: byte_q.push_back(8'($urandom_range(8'h3C, 8'h3E)));
              default: byte_q.push_back(8'($urandom_range(8'h7F, 8'hFF)));
            endcase
          end
        end
        if ($urandom_range(0, 9) == 0)
          byte_q.push_back(8'($urandom_range(CH_SP, CH_INTER_HI)));
        if ($urandom_range(0, 99) < 85) byte_q.push_back(finals[$urandom_range(0, 15)]);
        else byte_q.push_back(8'($urandom_range(CH_FINAL_LO, CH_FINAL_HI)));
      end else if (r < 60) begin
        // two-byte escape
        byte_q.push_back(CH_ESC);
        r = $urandom_range(0, 9);
        if (r < 4) byte_q.push_back(CH_D);
        else if (r < 8) byte_q.push_back(CH_M);
        else byte_q.push_back(8'($urandom_range(0, 255)));
      end else if (r < 68) begin
        // osc string, ended by bell or escape
        byte_q.push_back(CH_ESC);
        byte_q.push_back(CH_RBRK);
        repeat ($urandom_range(0, 5)) byte_q.push_back(8'($urandom_range(8'h20, 8'h7E)));
        byte_q.push_back(($urandom_range(0, 1) == 0) ? CH_BEL : CH_ESC);
      end else begin
        // plain text and control bytes
        repeat ($urandom_range(1, 4)) begin
          case ($urandom_range(0, 9))
            0: byte_q.push_back(CH_CR);
            1: byte_q.push_back(CH_LF);
            2: byte_q.push_back(CH_BS);
            3: byte_q.push_back(CH_TAB);
            4: byte_q.push_back(CH_BEL);
            default: byte_q.push_back(8'($urandom_range(0, 255)));
          endcase
        end
      end
    end
  endtask

  task automatic wait_drained();
    while (byte_q.size() != 0 || s_axis_tvalid || event_q.size() != 0) @(posedge clk_i);
  endtask

  initial begin
    logic [7:0]  directed_seq[28];
    int unsigned idle_set[4];
    int unsigned stall_set[4];
    idle_set = '{0, 64, 0, 9};
    stall_set = '{0, 0, 64, 9};
    // text extremes, bell, scroll escapes, unknown escape, saturation with empty
    // and spoiled parts in an sgr run, and a private sequence
    directed_seq = '{8'h00, CH_SP, 8'hFF, CH_CR, CH_BEL, CH_ESC, CH_D, CH_ESC, CH_M,
                     CH_ESC, CH_ESC, 8'h5A, CH_ESC, CH_LBRK, CH_NINE, CH_NINE,
                     CH_NINE, CH_NINE, CH_NINE, CH_SEMI, CH_COLON, CH_SEMI, CH_LC_M,
                     CH_ESC, CH_LBRK, CH_QUEST, 8'h31, CH_E};

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_seq[i]) byte_q.push_back(directed_seq[i]);
    wait_drained();

    for (int ph = 0; ph < 4; ph++) begin
      idle_pct <= idle_set[ph];
      stall_pct <= stall_set[ph];
      @(posedge clk_i);
      gen_stream(32);
      if (ph == 0) hold_go = 1'b1;
      wait_drained();
    end

    repeat (40) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // run limit
  initial begin
    #2000000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
